// ----- sv/scancode_to_ascii_fifo_core_macros.svh -----
// Assertion macros for the scancode to ASCII translator.
// Taken in by the top level; no other dependencies.
`ifndef SCANCODE_TO_ASCII_FIFO_CORE_MACROS_SVH
`define SCANCODE_TO_ASCII_FIFO_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off during reset
`define SC2A_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
		else $error("sc2a assertion failed");

// next-cycle implication, held off during reset
`define SC2A_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
		else $error("sc2a assertion failed");

`else

`define SC2A_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define SC2A_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

// ----- sv/sc2a_pkg.sv -----
// Shared types, scancode constants and the set-1 key map.
// No dependencies; used by every module of the translator.
package sc2a_pkg;

	// defaults for the top-level parameters
	localparam int FIFO_DEPTH_DEF = 256;
	localparam int TABLE_KEYS_DEF = 58;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// operation codes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_READ = 1'b1;

	// scancodes of interest
	localparam logic [7:0] SC_LSHIFT_DOWN = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_DOWN = 8'h36;
	localparam logic [7:0] SC_LSHIFT_UP   = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_UP   = 8'hB6;
	localparam logic [7:0] SC_CAPS_DOWN   = 8'h3A;
	localparam logic [7:0] SC_ESCAPE      = 8'h01;
	localparam logic [7:0] SC_PRESS_LIMIT = 8'h70;

	typedef struct packed {
		logic       operation;
		logic [7:0] scancode;
	} in_item_t;

	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_code;
		logic       snapshot_request;
		logic       overflow;
		logic [8:0] fill_count;
	} out_item_t;

	// what the back end has to do with a queued item
	typedef enum logic [1:0] {
		CMD_REPORT,
		CMD_PUSH,
		CMD_POP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [6:0] ch;
		logic       snap;
	} cmd_t;

	typedef struct packed {
		logic [6:0] shifted;
		logic [6:0] plain;
	} key_pair_t;

	// set-1 key map; rows not listed are unmapped
	function automatic key_pair_t key_entry(input logic [6:0] idx);
		key_pair_t kp;
		unique case (idx)
			7'd1:  kp = '{7'h1B, 7'h1B};
			7'd2:  kp = '{7'h21, 7'h31};
			7'd3:  kp = '{7'h40, 7'h32};
			7'd4:  kp = '{7'h23, 7'h33};
			7'd5:  kp = '{7'h24, 7'h34};
			7'd6:  kp = '{7'h25, 7'h35};
			7'd7:  kp = '{7'h5E, 7'h36};
			7'd8:  kp = '{7'h26, 7'h37};
			7'd9:  kp = '{7'h2A, 7'h38};
			7'd10: kp = '{7'h28, 7'h39};
			7'd11: kp = '{7'h29, 7'h30};
			7'd12: kp = '{7'h5F, 7'h2D};
			7'd13: kp = '{7'h2B, 7'h3D};
			7'd14: kp = '{7'h08, 7'h08};
			7'd15: kp = '{7'h09, 7'h09};
			7'd16: kp = '{7'h51, 7'h71};
			7'd17: kp = '{7'h57, 7'h77};
			7'd18: kp = '{7'h45, 7'h65};
			7'd19: kp = '{7'h52, 7'h72};
			7'd20: kp = '{7'h54, 7'h74};
			7'd21: kp = '{7'h59, 7'h79};
			7'd22: kp = '{7'h55, 7'h75};
			7'd23: kp = '{7'h49, 7'h69};
			7'd24: kp = '{7'h4F, 7'h6F};
			7'd25: kp = '{7'h50, 7'h70};
			7'd26: kp = '{7'h7B, 7'h5B};
			7'd27: kp = '{7'h7D, 7'h5D};
			7'd28: kp = '{7'h0A, 7'h0A};
			7'd30: kp = '{7'h41, 7'h61};
			7'd31: kp = '{7'h53, 7'h73};
			7'd32: kp = '{7'h44, 7'h64};
			7'd33: kp = '{7'h46, 7'h66};
			7'd34: kp = '{7'h47, 7'h67};
			7'd35: kp = '{7'h48, 7'h68};
			7'd36: kp = '{7'h4A, 7'h6A};
			7'd37: kp = '{7'h4B, 7'h6B};
			7'd38: kp = '{7'h4C, 7'h6C};
			7'd39: kp = '{7'h3A, 7'h3B};
			7'd40: kp = '{7'h22, 7'h27};
			7'd41: kp = '{7'h7E, 7'h60};
			7'd43: kp = '{7'h7C, 7'h5C};
			7'd44: kp = '{7'h5A, 7'h7A};
			7'd45: kp = '{7'h58, 7'h78};
			7'd46: kp = '{7'h43, 7'h63};
			7'd47: kp = '{7'h56, 7'h76};
			7'd48: kp = '{7'h42, 7'h62};
			7'd49: kp = '{7'h4E, 7'h6E};
			7'd50: kp = '{7'h4D, 7'h6D};
			7'd51: kp = '{7'h3C, 7'h2C};
			7'd52: kp = '{7'h3E, 7'h2E};
			7'd53: kp = '{7'h3F, 7'h2F};
			7'd57: kp = '{7'h20, 7'h20};
			default: kp = '{7'h00, 7'h00};
		endcase
		return kp;
	endfunction

endpackage

// ----- sv/sc2a_front.sv -----
// Front end: accepts items, tracks shift and caps lock, looks up the key map
// and turns each item into a back-end command. Depends on sc2a_pkg.
module sc2a_front #(
	parameter int TABLE_KEYS = sc2a_pkg::TABLE_KEYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sc2a_pkg::in_item_t cmd,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic              q_full,
	output logic              q_push,
	output sc2a_pkg::cmd_t    q_data
);

	logic               shift_q;
	logic               caps_q;
	logic               shift_nxt;
	logic               caps_nxt;
	logic               accept;
	logic               in_table;
	sc2a_pkg::key_pair_t kp;

	assign cmd_stall = q_full;
	assign accept    = cmd_valid && !q_full;
	assign q_push    = accept;

	// modifier tracking; only scancode items touch it
	always_comb begin
		shift_nxt = shift_q;
		caps_nxt  = caps_q;
		if (cmd.operation == sc2a_pkg::OP_SCAN) begin
			priority if (cmd.scancode == sc2a_pkg::SC_LSHIFT_DOWN ||
					cmd.scancode == sc2a_pkg::SC_RSHIFT_DOWN) begin
				shift_nxt = 1'b1;
			end else if (cmd.scancode == sc2a_pkg::SC_LSHIFT_UP ||
					cmd.scancode == sc2a_pkg::SC_RSHIFT_UP) begin
				shift_nxt = 1'b0;
			end else if (cmd.scancode == sc2a_pkg::SC_CAPS_DOWN) begin
				caps_nxt = !caps_q;
			end else begin
				caps_nxt = caps_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
		end else if (accept) begin
			shift_q <= shift_nxt;
			caps_q  <= caps_nxt;
		end
	end

	// classification and key map lookup
	assign kp       = sc2a_pkg::key_entry(cmd.scancode[6:0]);
	assign in_table = (cmd.scancode < 8'(TABLE_KEYS)) &&
			(cmd.scancode < sc2a_pkg::SC_PRESS_LIMIT);

	always_comb begin
		q_data.kind = sc2a_pkg::CMD_REPORT;
		q_data.ch   = (shift_nxt || caps_nxt) ? kp.shifted : kp.plain;
		q_data.snap = 1'b0;
		if (cmd.operation == sc2a_pkg::OP_READ) begin
			q_data.kind = sc2a_pkg::CMD_POP;
		end else begin
			q_data.snap = (cmd.scancode == sc2a_pkg::SC_ESCAPE);
			if (in_table && kp.plain != 7'd0) begin
				q_data.kind = sc2a_pkg::CMD_PUSH;
			end
		end
	end

endmodule

// ----- sv/sc2a_queue.sv -----
// Short command queue between front and back end, in flip-flops.
// Depends on sc2a_pkg for the command type and depth.
module sc2a_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sc2a_pkg::cmd_t push_data,
	input  logic           pop,
	output logic           head_valid,
	output sc2a_pkg::cmd_t head,
	output logic           full
);

	localparam int QD  = sc2a_pkg::QUEUE_DEPTH;
	localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	sc2a_pkg::cmd_t   slot_q [QD];
	logic [QPW-1:0]   wp_q;
	logic [QPW-1:0]   rp_q;
	logic [QCW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == QCW'(QD));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == QPW'(QD - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == QPW'(QD - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_data;
		end
	end

endmodule

// ----- sv/sc2a_back.sv -----
// Back end: runs queued commands against the character memory, keeps the
// pointers and count, and holds the result register. Depends on sc2a_pkg.
module sc2a_back #(
	parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  sc2a_pkg::cmd_t      q_head,
	output logic                q_pop,
	output logic                res_valid,
	output sc2a_pkg::out_item_t res,
	input  logic                res_stall
);

	localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [6:0]          mem [FIFO_DEPTH];
	logic [PW-1:0]       wp_q;
	logic [PW-1:0]       rp_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;
	logic                fifo_full;
	logic                fifo_empty;
	logic                take;
	logic                adv_out;
	logic                do_push;
	logic                do_pop;

	logic                valid_s1;
	logic                char_valid_s1;
	logic                snap_s1;
	logic                ovf_s1;
	logic [8:0]          fill_s1;
	logic [6:0]          rd_data_s1;

	logic                res_valid_q;
	sc2a_pkg::out_item_t res_q;

	assign fifo_full  = (count_q == CW'(FIFO_DEPTH));
	assign fifo_empty = (count_q == '0);

	// handshake between queue, stage 1 and result register
	assign adv_out = valid_s1 && (!res_valid_q || !res_stall);
	assign take    = q_valid && (!valid_s1 || adv_out);
	assign q_pop   = take;
	assign do_push = take && (q_head.kind == sc2a_pkg::CMD_PUSH) && !fifo_full;
	assign do_pop  = take && (q_head.kind == sc2a_pkg::CMD_POP) && !fifo_empty;

	always_comb begin
		count_nxt = count_q;
		if (do_push) begin
			count_nxt = count_q + 1'b1;
		end else if (do_pop) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// pointers, count and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (do_push) begin
				wp_q <= (wp_q == PW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_out) begin
				valid_s1 <= 1'b0;
			end
			if (adv_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 result fields
	always_ff @(posedge clk) begin
		if (take) begin
			char_valid_s1 <= do_pop;
			snap_s1       <= (q_head.kind != sc2a_pkg::CMD_POP) && q_head.snap;
			ovf_s1        <= (q_head.kind == sc2a_pkg::CMD_PUSH) && fifo_full;
			fill_s1       <= 9'(count_nxt);
		end
	end

	// character memory: one write or one registered read a cycle
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= q_head.ch;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			rd_data_s1 <= mem[rp_q];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_out) begin
			res_q.char_valid       <= char_valid_s1;
			res_q.char_code        <= char_valid_s1 ? rd_data_s1 : 7'd0;
			res_q.snapshot_request <= snap_s1;
			res_q.overflow         <= ovf_s1;
			res_q.fill_count       <= fill_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ----- sv/scancode_to_ascii_fifo_core.sv -----
// Set-1 scancode to ASCII translator with character FIFO, top level.
// Depends on sc2a_pkg, sc2a_front, sc2a_queue, sc2a_back and the macro header.
//
// Each item on cmd is either a scancode (shift and caps lock are tracked,
// mapped keys push one ASCII character, escape also flags a snapshot) or a
// read that pops the oldest character; every item gives exactly one result
// on res, in order. The front end classifies an item in the cycle it is
// accepted and hands it to a two-entry command queue; when nothing stalls,
// the back end executes one command per cycle on a single-port character
// memory, so the sustained rate is one item per cycle. An item passes the
// queue slot, stage 1 and the result register before its result is shown.
// A push on a full FIFO drops the character and sets overflow. The character
// memory needs no clearing after reset: only written entries are ever read.
`include "scancode_to_ascii_fifo_core_macros.svh"

module scancode_to_ascii_fifo_core #(
	parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF,
	parameter int TABLE_KEYS = sc2a_pkg::TABLE_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  sc2a_pkg::in_item_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output sc2a_pkg::out_item_t res
);

	logic           q_full;
	logic           q_push;
	sc2a_pkg::cmd_t q_data;
	logic           q_valid;
	logic           q_pop;
	sc2a_pkg::cmd_t q_head;

	// classification
	sc2a_front #(
		.TABLE_KEYS(TABLE_KEYS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_data)
	);

	// decoupling queue
	sc2a_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head      (q_head),
		.full      (q_full)
	);

	// execution and result
	sc2a_back #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res      (res),
		.res_stall(res_stall)
	);

	// a read result never carries scancode flags
	`SC2A_ASSERT_IMP(a_read_no_flags, clk, arst_n, res_valid && res.char_valid, !res.snapshot_request && !res.overflow)

	// a dropped character means the FIFO stayed full
	`SC2A_ASSERT_IMP(a_ovf_full, clk, arst_n, res_valid && res.overflow, res.fill_count == 9'(FIFO_DEPTH))

	// no character code without a popped character
	`SC2A_ASSERT_IMP(a_code_zero, clk, arst_n, res_valid && !res.char_valid, res.char_code == 7'd0)

endmodule
